// ===== rtl/tocq_pkg.sv =====
// shared types and codes for the tick ordered command queue
package tocq_pkg;

  localparam int TICK_W  = 24;
  localparam int CODE_W  = 8;
  localparam int EXEC_W  = 16;
  localparam int EXTRA_W = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_TOP    = 2'd1,
    REQ_POP    = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_APPLY
  } state_e;

  typedef struct packed {
    logic signed [EXTRA_W-1:0] extra_two;
    logic signed [EXTRA_W-1:0] extra_one;
    logic [EXEC_W-1:0]         executor;
    logic [CODE_W-1:0]         code;
    logic [TICK_W-1:0]         tick;
  } entry_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic   insert;
    logic   erase;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ===== rtl/tocq_cell.sv =====
// one slot of the sorted command store, shifting with its neighbors
module tocq_cell #(
  parameter int CNT_W = 7
) (
  input  logic                clk,
  input  logic [CNT_W-1:0]    cell_index,
  input  logic [CNT_W-1:0]    count,
  input  logic [CNT_W-1:0]    cursor,
  input  tocq_pkg::cell_ctrl_t ctrl,
  input  logic                left_shift,
  input  tocq_pkg::entry_t    left_data,
  input  tocq_pkg::entry_t    right_data,
  output logic                shift_out,
  output tocq_pkg::entry_t    data,
  output tocq_pkg::entry_t    read_data
);
  import tocq_pkg::*;

  logic occupied;
  logic at_end;

  assign occupied  = cell_index < count;
  assign at_end    = cell_index == count;
  // this slot holds a later tick, so it moves right to make room
  assign shift_out = occupied && (ctrl.new_entry.tick < data.tick);
  assign read_data = (cell_index == cursor) ? data : '0;

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (left_shift) begin
        data <= left_data;
      end else if (shift_out || at_end) begin
        data <= ctrl.new_entry;
      end
    end else if (ctrl.erase && cell_index >= cursor) begin
      data <= right_data;
    end
  end

endmodule

// ===== rtl/tick_ordered_command_queue_top.sv =====
// After an input transfer the request passes the fetch state, which registers the cursor entry,
// then the apply state, which loads the output register and waits while the output stalls.
// The sequencer handles one request at a time; the cursor entry is read through a registered
// one-hot select over the cell row. Insert and erase shift part of the cell row when applied.
// Reset (synchronous, rst high) empties the queue, zeroes the cursor and the erase id;
// stored entries are not cleared.
module tick_ordered_command_queue_top #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command_tick, command_code, executor_id, extra_one, extra_two, current_tick
  input  logic [135:0] s_tdata,
  // req_type
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // entry_valid, out_tick, out_code, out_executor, out_extra_one, out_extra_two,
  // late_insert, queue_full, entry_erased, zero pad
  output logic [119:0] m_tdata,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);
  import tocq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_e            state, state_next;
  req_e              req;
  entry_t            req_entry;
  logic [TICK_W-1:0] req_now;
  logic [CODE_W-1:0] erase_code;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cursor;
  entry_t            read_q;
  entry_t            read_any;
  cell_ctrl_t        ctrl;
  logic              apply_fire;
  logic              cursor_hit;
  logic              store_full;
  logic              do_erase;

  logic              res_valid, res_late, res_full, res_erased;
  entry_t            res_entry;

  logic   [QUEUE_DEPTH:0]   shift_chain;
  entry_t [QUEUE_DEPTH-1:0] cell_data;
  entry_t [QUEUE_DEPTH-1:0] cell_read;

  assign s_tready   = state == ST_IDLE;
  assign apply_fire = (state == ST_APPLY) && (!m_tvalid || m_tready);
  assign cursor_hit = cursor < count;
  assign store_full = count == CNT_W'(QUEUE_DEPTH);
  assign do_erase   = (req == REQ_POP) && cursor_hit && (read_q.code == erase_code);

  always_comb begin
    ctrl.new_entry = req_entry;
    ctrl.insert    = apply_fire && (req == REQ_INSERT) && !store_full;
    ctrl.erase     = apply_fire && do_erase;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_APPLY;
      ST_APPLY: if (apply_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req                 <= req_e'(s_tuser);
      req_entry.tick      <= s_tdata[23:0];
      req_entry.code      <= s_tdata[31:24];
      req_entry.executor  <= s_tdata[47:32];
      req_entry.extra_one <= s_tdata[79:48];
      req_entry.extra_two <= s_tdata[111:80];
      req_now             <= s_tdata[135:112];
    end
  end

  // cell row
  assign shift_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end
    tocq_cell #(.CNT_W(CNT_W)) u_cell (
      .clk        (clk),
      .cell_index (CNT_W'(i)),
      .count      (count),
      .cursor     (cursor),
      .ctrl       (ctrl),
      .left_shift (shift_chain[i]),
      .left_data  (left_d),
      .right_data (right_d),
      .shift_out  (shift_chain[i+1]),
      .data       (cell_data[i]),
      .read_data  (cell_read[i])
    );
  end

  // one-hot select: only the cursor cell drives nonzero data
  always_comb begin
    read_any = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      read_any = read_any | cell_read[k];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      read_q <= read_any;
    end
  end

  // queue state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cursor     <= '0;
      erase_code <= '0;
    end else begin
      if (cfg_wr_en) begin
        erase_code <= cfg_wr_data;
      end
      if (apply_fire) begin
        case (req)
          REQ_INSERT: if (!store_full) count <= count + 1'b1;
          REQ_POP: begin
            if (do_erase) begin
              count <= count - 1'b1;
            end else if (cursor_hit) begin
              cursor <= cursor + 1'b1;
            end
          end
          REQ_CLEAR: begin
            count  <= '0;
            cursor <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (apply_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      res_valid  <= ((req == REQ_TOP) || (req == REQ_POP)) && cursor_hit;
      res_entry  <= (((req == REQ_TOP) || (req == REQ_POP)) && cursor_hit) ? read_q : '0;
      res_late   <= (req == REQ_INSERT) && (req_entry.tick < req_now);
      res_full   <= (req == REQ_INSERT) && store_full;
      res_erased <= do_erase;
    end
  end

  assign m_tdata = {4'b0000, res_erased, res_full, res_late, res_entry.extra_two,
                    res_entry.extra_one, res_entry.executor, res_entry.code,
                    res_entry.tick, res_valid};

`ifndef SYNTHESIS
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst) cursor <= count)
    else $error("cursor beyond entry count");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond depth");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    apply_fire |=> m_tvalid)
    else $error("applied request gave no result");
  a_erase_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_erased |-> res_valid)
    else $error("erase reported without an entry");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the tick ordered command queue, checked against a predictor
module tb_top;
  import tocq_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AT     = 450;

  typedef struct packed {
    req_e              req;
    entry_t            ent;
    logic [TICK_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic   erased;
    logic   full;
    logic   late;
    entry_t ent;
    logic   valid;
  } resp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // command_tick, command_code, executor_id, extra_one, extra_two, current_tick
  logic [135:0] s_tdata = '0;
  // req_type
  logic [1:0]   s_tuser = REQ_TOP;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // entry_valid, out_tick, out_code, out_executor, out_extra_one, out_extra_two,
  // late_insert, queue_full, entry_erased, zero pad
  logic [119:0] m_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [7:0]   cfg_wr_data = '0;

  // predictor state
  entry_t      sorted_cmds[$];
  int          pop_cursor = 0;
  logic [7:0]  erase_code = '0;

  cmd_t        pending_cmds[$];
  resp_t       expected_results[$];
  cmd_t        offered_cmd;
  resp_t       got;
  resp_t       want;
  int          errors = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 0;
  bit          no_idle = 0;
  int          stuck_cycles = 0;

  tick_ordered_command_queue_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void add_cmd(cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic resp_t compute_response(cmd_t c);
    resp_t r;
    int pos;
    r = '0;
    case (c.req)
      REQ_INSERT: begin
        r.late = c.ent.tick < c.now;
        if (sorted_cmds.size() >= QUEUE_DEPTH) begin
          r.full = 1'b1;
        end else begin
          // equal ticks keep arrival order
          pos = sorted_cmds.size();
          for (int i = 0; i < sorted_cmds.size(); i++) begin
            if (c.ent.tick < sorted_cmds[i].tick) begin
              pos = i;
              break;
            end
          end
          sorted_cmds.insert(pos, c.ent);
        end
      end
      REQ_TOP, REQ_POP: begin
        if (pop_cursor < sorted_cmds.size()) begin
          r.valid = 1'b1;
          r.ent = sorted_cmds[pop_cursor];
          if (c.req == REQ_POP) begin
            if (r.ent.code == erase_code) begin
              sorted_cmds.delete(pop_cursor);
              r.erased = 1'b1;
            end else begin
              pop_cursor++;
            end
          end
        end
      end
      default: begin
        sorted_cmds.delete();
        pop_cursor = 0;
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t make_cmd(req_e req, logic [23:0] tick, logic [7:0] code,
                                    logic [15:0] exec, logic [31:0] e1, logic [31:0] e2,
                                    logic [23:0] now);
    cmd_t c;
    c.req = req;
    c.ent.tick = tick;
    c.ent.code = code;
    c.ent.executor = exec;
    c.ent.extra_one = e1;
    c.ent.extra_two = e2;
    c.now = now;
    return c;
  endfunction

  function automatic cmd_t random_cmd(int w_ins, int w_top, int w_pop);
    cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    c.req = (roll < w_ins) ? REQ_INSERT :
            (roll < w_ins + w_top) ? REQ_TOP :
            (roll < w_ins + w_top + w_pop) ? REQ_POP : REQ_CLEAR;
    // mostly a narrow tick range so that ties are common
    roll = $urandom_range(0, 99);
    if (roll < 70)      c.ent.tick = TICK_W'($urandom_range(0, 40));
    else if (roll < 85) c.ent.tick = TICK_W'($urandom);
    else                c.ent.tick = (roll < 92) ? '0 : '1;
    roll = $urandom_range(0, 99);
    if (roll < 60)      c.now = TICK_W'(c.ent.tick + $urandom_range(0, 2) - 1);
    else if (roll < 85) c.now = TICK_W'($urandom);
    else                c.now = (roll < 92) ? '0 : '1;
    roll = $urandom_range(0, 99);
    if (roll < 50)      c.ent.code = erase_code;
    else if (roll < 75) c.ent.code = CODE_W'($urandom);
    else                c.ent.code = erase_code ^ 8'h01;
    c.ent.executor = EXEC_W'($urandom);
    c.ent.extra_one = $urandom;
    c.ent.extra_two = $urandom;
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_erase_code(logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    erase_code = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(int n, int w_ins, int w_top, int w_pop);
    for (int i = 0; i < n; i++)
      add_cmd(random_cmd(w_ins, w_top, w_pop));
    wait_drained();
  endtask

  initial begin
    // directed part, erase code at its reset value of zero
    add_cmd(make_cmd(REQ_TOP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_POP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_INSERT, 24'hFFFFFF, 8'h00, 16'hFFFF,
                     32'h7FFFFFFF, 32'h80000000, 24'h000000));
    add_cmd(make_cmd(REQ_INSERT, 24'h000000, 8'hFF, 16'h0000,
                     32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF));
    add_cmd(make_cmd(REQ_INSERT, 100, 8'h07, 16'h1234, -1, 1, 100));
    add_cmd(make_cmd(REQ_INSERT, 100, 8'h00, 16'h5678, 5, -5, 101));
    add_cmd(make_cmd(REQ_INSERT, 100, 8'h09, 16'h9ABC, 0, 0, 99));
    add_cmd(make_cmd(REQ_TOP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_POP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_TOP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_POP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_POP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_TOP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_POP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_POP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_POP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_TOP, 0, 0, 0, 0, 0, 0));
    // insert ahead of the cursor does not move it
    add_cmd(make_cmd(REQ_INSERT, 50, 8'h00, 16'h0001, 2, 3, 10));
    add_cmd(make_cmd(REQ_TOP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_TOP, 0, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(REQ_INSERT, 5, 8'h00, 16'h0002, 4, 6, 5));
    add_cmd(make_cmd(REQ_POP, 0, 0, 0, 0, 0, 0));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // insert heavy with no clears so the store fills and drops inserts
    write_erase_code(8'hFF);
    run_random(250, 65, 15, 20);

    // pop heavy, no random idling on either side
    write_erase_code(8'h00);
    no_idle = 1;
    run_random(200, 35, 20, 40);
    no_idle = 0;

    write_erase_code(CODE_W'($urandom));
    run_random(250, 45, 15, 35);

    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("** tick_ordered_command_queue_top: PASSED **");
    else
      $display("** tick_ordered_command_queue_top: FAILED **");
    $finish;
  end

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(), compute_response(offered_cmd));
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() != 0 && (no_idle || $urandom_range(0, 99) >= 25)) begin
          offered_cmd = pending_cmds[0];
          pending_cmds.delete(0);
          s_tvalid <= 1'b1;
          s_tdata <= {offered_cmd.now, offered_cmd.ent};
          s_tuser <= offered_cmd.req;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = m_tdata[115:0];
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          check_field("entry_valid", 64'(want.valid), 64'(got.valid));
          check_field("out_tick", 64'(want.ent.tick), 64'(got.ent.tick));
          check_field("out_code", 64'(want.ent.code), 64'(got.ent.code));
          check_field("out_executor", 64'(want.ent.executor), 64'(got.ent.executor));
          check_field("out_extra_one", 64'(want.ent.extra_one), 64'(got.ent.extra_one));
          check_field("out_extra_two", 64'(want.ent.extra_two), 64'(got.ent.extra_two));
          check_field("late_insert", 64'(want.late), 64'(got.late));
          check_field("queue_full", 64'(want.full), 64'(got.full));
          check_field("entry_erased", 64'(want.erased), 64'(got.erased));
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("** tick_ordered_command_queue_top: FAILED **");
        $finish;
      end
    end
  end

endmodule
